FILE: src/srsb_pkg.sv
// Package with shared types, constants and the source-to-level table for the SR/stack bank block.
`timescale 1ns / 1ps

package srsb_pkg;

	// Operation codes carried by an input item.
	typedef enum logic [1:0] {
		FN_WRITE_SR = 2'd0,
		FN_RECHECK  = 2'd1,
		FN_WRITE_SP = 2'd2,
		FN_ACK      = 2'd3
	} func_t;

	// Configuration register indexes.
	localparam logic CFG_FAMILY = 1'b0;
	localparam logic CFG_VBR    = 1'b1;

	// Stack pointer banks.
	typedef enum logic [1:0] {
		BANK_USER   = 2'd0,
		BANK_INT    = 2'd1,
		BANK_MASTER = 2'd2
	} bank_t;

	localparam int          ENABLE_MASTER_BIT = 14;
	localparam int          SR_SUPER_BIT      = 13;
	localparam int          SR_MASTER_BIT     = 12;
	localparam int          TOP_SOURCE        = 13;
	localparam logic [15:0] SR_RESET          = 16'h2700;
	localparam logic [31:0] VEC_OFFSET        = 32'h0000_0060;

	// Result of one interrupt check.
	typedef struct packed {
		logic        hit;
		logic [2:0]  level;
		logic [31:0] addr;
	} irq_t;

	// Architectural state visible to the rest of the block.
	typedef struct packed {
		logic [15:0] sr;
		logic [31:0] sp;
		logic        pending;
	} core_state_t;

	// Fixed mapping from request source number to interrupt level.
	function automatic logic [2:0] level_of(input logic [3:0] src);
		logic [2:0] lvl;
		unique case (src)
			4'd0, 4'd1, 4'd2:          lvl = 3'd1;
			4'd3:                      lvl = 3'd2;
			4'd4, 4'd5, 4'd6:          lvl = 3'd3;
			4'd7, 4'd8, 4'd9, 4'd10:   lvl = 3'd4;
			4'd11, 4'd12:              lvl = 3'd5;
			4'd13, 4'd14:              lvl = 3'd6;
			4'd15:                     lvl = 3'd7;
			default:                   lvl = 3'd1;
		endcase
		return lvl;
	endfunction

	// Bank chosen by the S and M bits of a status value.
	function automatic bank_t bank_of(input logic [15:0] sr, input logic mbit_ok);
		bank_t b;
		priority if (!sr[SR_SUPER_BIT]) begin
			b = BANK_USER;
		end else if (mbit_ok && sr[SR_MASTER_BIT]) begin
			b = BANK_MASTER;
		end else begin
			b = BANK_INT;
		end
		return b;
	endfunction

endpackage

FILE: src/srsb_irq_check.sv
// Interrupt priority check: priority encoder, level table, mask compare and vector address.
`timescale 1ns / 1ps

module srsb_irq_check (
	input  logic               enable,
	input  logic [2:0]         mask,
	input  logic               pending,
	input  logic [14:0]        chip_request,
	input  logic [14:0]        chip_enable,
	input  logic [31:0]        vector_base,
	output srsb_pkg::irq_t     irq
);

	logic [13:0] live;
	logic        found;
	logic [3:0]  src;
	logic [2:0]  lvl;
	logic        take;

	assign live = chip_request[13:0] & chip_enable[13:0];

	// Highest live source wins; later iterations override earlier ones.
	always_comb begin
		found = 1'b0;
		src   = 4'd0;
		for (int b = 0; b <= srsb_pkg::TOP_SOURCE; b++) begin
			if (live[b]) begin
				found = 1'b1;
				src   = 4'(b);
			end
		end
	end

	assign lvl  = srsb_pkg::level_of(src);
	assign take = enable && !pending && chip_enable[srsb_pkg::ENABLE_MASTER_BIT]
		&& found && (lvl > mask);

	always_comb begin
		irq.hit   = take;
		irq.level = take ? lvl : 3'd0;
		irq.addr  = take ? (vector_base + srsb_pkg::VEC_OFFSET + {27'd0, lvl, 2'b00}) : 32'd0;
	end

endmodule

FILE: src/srsb_state.sv
// Status register, active and banked stack pointers and the interrupt pending flag.
`timescale 1ns / 1ps

module srsb_state (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  srsb_pkg::func_t         op,
	input  logic [15:0]             new_status,
	input  logic [31:0]             stack_value,
	input  logic [1:0]              cpu_family,
	input  srsb_pkg::irq_t          irq,
	output srsb_pkg::core_state_t   cur,
	output srsb_pkg::core_state_t   nxt
);

	logic [15:0]     sr_q;
	logic [31:0]     sp_q;
	logic [31:0]     user_sp_q;
	logic [31:0]     int_sp_q;
	logic [31:0]     master_sp_q;
	logic            pending_q;

	logic            mbit_ok;
	logic            wr_sr;
	srsb_pkg::bank_t old_bank;
	srsb_pkg::bank_t new_bank;
	logic [31:0]     user_n;
	logic [31:0]     int_n;
	logic [31:0]     master_n;
	logic [31:0]     bank_sp;

	assign mbit_ok  = cpu_family[1];
	assign wr_sr    = (op == srsb_pkg::FN_WRITE_SR);
	assign old_bank = srsb_pkg::bank_of(sr_q, mbit_ok);
	assign new_bank = srsb_pkg::bank_of(new_status, mbit_ok);

	// Save A7 into the old bank first, then load from the new bank.
	assign user_n   = (wr_sr && old_bank == srsb_pkg::BANK_USER)   ? sp_q : user_sp_q;
	assign int_n    = (wr_sr && old_bank == srsb_pkg::BANK_INT)    ? sp_q : int_sp_q;
	assign master_n = (wr_sr && old_bank == srsb_pkg::BANK_MASTER) ? sp_q : master_sp_q;

	always_comb begin
		priority if (new_bank == srsb_pkg::BANK_USER) begin
			bank_sp = user_n;
		end else if (new_bank == srsb_pkg::BANK_MASTER) begin
			bank_sp = master_n;
		end else begin
			bank_sp = int_n;
		end
	end

	always_comb begin
		nxt.sr      = sr_q;
		nxt.sp      = sp_q;
		nxt.pending = pending_q || irq.hit;
		unique case (op)
			srsb_pkg::FN_WRITE_SR: begin
				nxt.sr = new_status;
				nxt.sp = bank_sp;
			end
			srsb_pkg::FN_RECHECK: begin
			end
			srsb_pkg::FN_WRITE_SP: begin
				nxt.sp = stack_value;
			end
			srsb_pkg::FN_ACK: begin
				nxt.pending = 1'b0;
			end
		endcase
	end

	assign cur.sr      = sr_q;
	assign cur.sp      = sp_q;
	assign cur.pending = pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q        <= srsb_pkg::SR_RESET;
			sp_q        <= 32'd0;
			user_sp_q   <= 32'd0;
			int_sp_q    <= 32'd0;
			master_sp_q <= 32'd0;
			pending_q   <= 1'b0;
		end else if (step) begin
			sr_q        <= nxt.sr;
			sp_q        <= nxt.sp;
			user_sp_q   <= user_n;
			int_sp_q    <= int_n;
			master_sp_q <= master_n;
			pending_q   <= nxt.pending;
		end
	end

endmodule

FILE: src/status_register_stack_bank_irq_check_core.sv
// Top level of the status register, stack pointer banking and interrupt check block.
`timescale 1ns / 1ps

// This block keeps a 68k-style status register, the active stack pointer A7 with its
// user, interrupt and master banks, and an interrupt pending flag. Each input transfer
// carries one operation: write the status register (banking A7 and, if the interrupt
// mask changed, checking interrupts), recheck interrupts, write A7, or acknowledge the
// pending interrupt. Every operation yields exactly one result transfer with the state
// after the operation and any interrupt it raised, including the autovector address
// vector_base + 0x60 + level * 4. The block takes one transfer per clock cycle while
// results are drained: an item is captured in an input register, and once the result
// register is free a single pass of banking, priority encoding and a 32-bit add updates
// the state and loads the result register. The input register still accepts an item
// while a finished result waits for out_ready if it is itself empty, so throughput
// drops only when both registers are full. Configuration writes (index 0 cpu_family,
// index 1 vector_base) are always ready and must only be issued while the block is idle.

module status_register_stack_bank_irq_check_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [15:0] new_status,
	input  logic [14:0] chip_request,
	input  logic [14:0] chip_enable,
	input  logic [31:0] stack_value,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] status_now,
	output logic [31:0] active_stack,
	output logic        irq_raised,
	output logic [2:0]  irq_level_out,
	output logic [31:0] vector_address,
	output logic        irq_pending_out,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	// Configuration registers.
	logic [1:0]  cpu_family_q;
	logic [31:0] vector_base_q;

	// Input stage.
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [15:0] new_status_s1;
	logic [14:0] chip_request_s1;
	logic [14:0] chip_enable_s1;
	logic [31:0] stack_value_s1;

	// Result register.
	logic        out_valid_q;

	logic                  advance;
	srsb_pkg::func_t       op;
	logic                  check_en;
	logic [2:0]            check_mask;
	srsb_pkg::irq_t        irq;
	srsb_pkg::core_state_t cur;
	srsb_pkg::core_state_t nxt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_family_q  <= 2'd0;
			vector_base_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				srsb_pkg::CFG_FAMILY: cpu_family_q  <= cfg_data[1:0];
				srsb_pkg::CFG_VBR:    vector_base_q <= cfg_data;
			endcase
		end
	end

	// The stored item moves on whenever the result register is empty or being drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// The operation code is reset so that the decode always sees a known value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_s1 <= srsb_pkg::FN_RECHECK;
		end else if (in_valid && in_ready) begin
			func_s1 <= func;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			new_status_s1   <= new_status;
			chip_request_s1 <= chip_request;
			chip_enable_s1  <= chip_enable;
			stack_value_s1  <= stack_value;
		end
	end

	assign op = srsb_pkg::func_t'(func_s1);

	// A status write checks against the new mask, and only when the mask changes.
	always_comb begin
		check_en   = 1'b0;
		check_mask = cur.sr[10:8];
		unique case (op)
			srsb_pkg::FN_WRITE_SR: begin
				check_en   = (new_status_s1[10:8] != cur.sr[10:8]);
				check_mask = new_status_s1[10:8];
			end
			srsb_pkg::FN_RECHECK: begin
				check_en = 1'b1;
			end
			srsb_pkg::FN_WRITE_SP, srsb_pkg::FN_ACK: begin
				check_en = 1'b0;
			end
		endcase
	end

	srsb_irq_check u_irq_check (
		.enable       (check_en),
		.mask         (check_mask),
		.pending      (cur.pending),
		.chip_request (chip_request_s1),
		.chip_enable  (chip_enable_s1),
		.vector_base  (vector_base_q),
		.irq          (irq)
	);

	srsb_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.op          (op),
		.new_status  (new_status_s1),
		.stack_value (stack_value_s1),
		.cpu_family  (cpu_family_q),
		.irq         (irq),
		.cur         (cur),
		.nxt         (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_now      <= nxt.sr;
			active_stack    <= nxt.sp;
			irq_raised      <= irq.hit;
			irq_level_out   <= irq.level;
			vector_address  <= irq.addr;
			irq_pending_out <= nxt.pending;
		end
	end

	assign out_valid = out_valid_q;

	// A new interrupt is never raised while one is already pending.
	a_no_raise_when_pending: assert property (@(posedge clk) disable iff (!arst_n)
		advance && irq.hit |-> !cur.pending)
		else $error("interrupt raised while one was pending");

	// A raised interrupt leaves the pending flag set in the same result.
	a_raise_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && irq_raised |-> irq_pending_out && irq_level_out != 3'd0)
		else $error("raised interrupt without pending flag or level");

	// Without a raised interrupt the level and vector fields are zero.
	a_quiet_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !irq_raised |-> irq_level_out == 3'd0 && vector_address == 32'd0)
		else $error("level or vector nonzero with nothing raised");

	// Every item that moves on shows up as a result in the next cycle.
	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("stored item produced no result");

endmodule
